@@ sv/ebap_pkg.sv @@
// ebap_pkg: shared types, window constants and size tables for the
// expansion board placer. No dependencies.
package ebap_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ENTRY_W         = 65;
    localparam int IN_W            = 32;
    localparam int OUT_W           = 112;

    localparam logic [31:0] Z3_LOW      = 32'h1000_0000;
    localparam logic [31:0] Z3_HIGH     = 32'h8000_0000;
    localparam logic [31:0] Z2_MEM_LOW  = 32'h0020_0000;
    localparam logic [31:0] Z2_MEM_HIGH = 32'h00a0_0000;
    localparam logic [31:0] Z2_MEM_P2M  = 32'h0040_0000;
    localparam logic [31:0] Z2_MEM_P4M  = 32'h0060_0000;
    localparam logic [31:0] Z2_IO_LOW   = 32'h00e9_0000;
    localparam logic [31:0] Z2_IO_HIGH  = 32'h00f0_0000;
    localparam logic [31:0] Z2_XIO_LOW  = 32'h00a0_0000;
    localparam logic [31:0] Z2_XIO_HIGH = 32'h00b8_0000;

    localparam logic [30:0] SZ_4M = 31'h0040_0000;
    localparam logic [30:0] SZ_8M = 31'h0080_0000;

    typedef enum logic [2:0] {
        ST_PLACED  = 3'd0,
        ST_INVALID = 3'd1,
        ST_SHUTUP  = 3'd2,
        ST_STOP    = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SUM,
        S_ALIGN,
        S_FIT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic        invalid;
        logic        z3;
        logic        mem;
        logic        related;
        logic        cant_shutup;
        logic [30:0] phys;
        logic [30:0] logical;
        logic        needs;
    } dec_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] base;
        logic        z3;
        logic        mem;
        logic [30:0] phys;
        logic [30:0] logical;
        logic [4:0]  slot;
        logic        needs;
    } res_t;

    function automatic logic [30:0] normal_size(input logic [2:0] code);
        logic [30:0] s;
        case (code)
            3'd0:    s = 31'h0080_0000;
            3'd1:    s = 31'h0001_0000;
            3'd2:    s = 31'h0002_0000;
            3'd3:    s = 31'h0004_0000;
            3'd4:    s = 31'h0008_0000;
            3'd5:    s = 31'h0010_0000;
            3'd6:    s = 31'h0020_0000;
            default: s = 31'h0040_0000;
        endcase
        return s;
    endfunction

    function automatic logic [30:0] extended_size(input logic [2:0] code);
        logic [30:0] s;
        case (code)
            3'd0:    s = 31'h0100_0000;
            3'd1:    s = 31'h0200_0000;
            3'd2:    s = 31'h0400_0000;
            3'd3:    s = 31'h0800_0000;
            3'd4:    s = 31'h1000_0000;
            3'd5:    s = 31'h2000_0000;
            3'd6:    s = 31'h4000_0000;
            default: s = 31'h0000_0000;
        endcase
        return s;
    endfunction

    // codes 2..13; 0 and 1 are handled by the caller
    function automatic logic [30:0] log_code_bytes(input logic [3:0] code);
        logic [30:0] s;
        case (code)
            4'd2:    s = 31'h0001_0000;
            4'd3:    s = 31'h0002_0000;
            4'd4:    s = 31'h0004_0000;
            4'd5:    s = 31'h0008_0000;
            4'd6:    s = 31'h0010_0000;
            4'd7:    s = 31'h0020_0000;
            4'd8:    s = 31'h0040_0000;
            4'd9:    s = 31'h0060_0000;
            4'd10:   s = 31'h0080_0000;
            4'd11:   s = 31'h00a0_0000;
            4'd12:   s = 31'h00c0_0000;
            4'd13:   s = 31'h00e0_0000;
            default: s = 31'h0000_0000;
        endcase
        return s;
    endfunction

endpackage

@@ sv/ebap_ram.sv @@
// ebap_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module ebap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

@@ sv/ebap_decode.sv @@
// ebap_decode: decodes one request's autoconfig bytes into bus, type, sizes, flags.
// Depends on ebap_pkg.
module ebap_decode
    import ebap_pkg::*;
(
    input  logic [IN_W-1:0] data,
    output dec_t            dec
);

    logic [7:0]  type_b;
    logic [7:0]  flags_b;
    logic [15:0] maker;
    logic [3:0]  logsiz;

    assign type_b  = data[7:0];
    assign flags_b = ~data[15:8];
    assign maker   = ~data[31:16];

    always_comb
    begin
        dec.z3          = (type_b[7:6] == 2'd2);
        dec.mem         = type_b[5];
        dec.related     = type_b[3];
        dec.cant_shutup = flags_b[6];
        dec.phys        = (dec.z3 && flags_b[5]) ? extended_size(type_b[2:0])
                                                 : normal_size(type_b[2:0]);
        logsiz          = dec.z3 ? flags_b[3:0] : 4'd0;
        dec.invalid     = !type_b[7] || (dec.phys == 31'd0) || (logsiz > 4'd13)
                          || (maker == 16'd0);
        case (logsiz)
            4'd0:    dec.logical = dec.phys;
            4'd1:    dec.logical = dec.mem ? 31'd0 : dec.phys;
            default: dec.logical = log_code_bytes(logsiz);
        endcase
        dec.needs       = dec.mem && (dec.logical == 31'd0);
    end

endmodule

@@ sv/ebap_seq.sv @@
// ebap_seq: sequencer that scans the board table through one compare unit,
// computes the aligned base, checks fit, records the board and builds the result.
// Depends on ebap_pkg; drives an ebap_ram instance in the top level.
module ebap_seq
    import ebap_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CW          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dec_t               dec,
    input  logic               cfg_xio,
    output logic               out_valid,
    input  logic               out_ready,
    output res_t               res,
    output logic               ram_we,
    output logic [AW-1:0]      ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata,
    output logic [AW-1:0]      ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata
);

    state_t      state_reg,   state_next;
    dec_t        dec_reg,     dec_next;
    logic [31:0] lo_reg,      lo_next;
    logic [31:0] hi_reg,      hi_next;
    logic [31:0] highest_reg, highest_next;
    logic [30:0] hsize_reg,   hsize_next;
    logic        found_reg,   found_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic        pend_reg,    pend_next;
    logic        xio_reg,     xio_next;
    logic [32:0] p_reg,       p_next;
    logic [33:0] b_reg,       b_next;
    status_t     status_reg,  status_next;
    logic [CW-1:0] count_reg, count_next;
    logic [4:0]  slot_reg,    slot_next;
    logic        related_reg, related_next;
    logic        out_valid_reg, out_valid_next;
    res_t        res_reg,     res_next;

    logic [31:0] e_start;
    logic [30:0] e_size;
    logic        e_z3;
    logic        e_mem;
    logic        hit;
    logic [33:0] phys_w;
    logic [33:0] mask_w;
    logic [33:0] aligned_w;
    logic [33:0] end_w;
    logic [4:0]  new_slot;

    assign e_start = ram_rdata[31:0];
    assign e_size  = ram_rdata[62:32];
    assign e_z3    = ram_rdata[63];
    assign e_mem   = ram_rdata[64];
    assign hit     = (e_z3 == dec_reg.z3) && (e_mem == dec_reg.mem) && (e_start >= lo_reg)
                     && (e_start < hi_reg) && (e_start >= highest_reg);

    assign phys_w    = {3'b000, dec_reg.phys};
    assign mask_w    = phys_w - 34'd1;
    assign aligned_w = ({1'b0, p_reg} + mask_w) & ~mask_w;
    assign end_w     = b_reg + phys_w;
    assign new_slot  = related_reg ? slot_reg : slot_reg + 5'd1;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign res       = res_reg;
    assign ram_raddr = rd_idx_reg[AW-1:0];
    assign ram_waddr = count_reg[AW-1:0];
    assign ram_wdata = {dec_reg.mem, dec_reg.z3, dec_reg.phys, b_reg[31:0]};

    always_comb
    begin
        state_next     = state_reg;
        dec_next       = dec_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        highest_next   = highest_reg;
        hsize_next     = hsize_reg;
        found_next     = found_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        xio_next       = xio_reg;
        p_next         = p_reg;
        b_next         = b_reg;
        status_next    = status_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        related_next   = related_reg;
        out_valid_next = out_valid_reg && !out_ready;
        res_next       = res_reg;
        ram_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    dec_next    = dec;
                    rd_idx_next = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    hsize_next  = '0;
                    xio_next    = 1'b0;
                    if (dec.z3)
                    begin
                        lo_next = Z3_LOW;
                        hi_next = Z3_HIGH;
                    end
                    else if (dec.mem)
                    begin
                        lo_next = Z2_MEM_LOW;
                        hi_next = Z2_MEM_HIGH;
                    end
                    else
                    begin
                        lo_next = Z2_IO_LOW;
                        hi_next = Z2_IO_HIGH;
                    end
                    highest_next = lo_next;
                    if (count_reg >= CW'(TABLE_DEPTH))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_FIN;
                    end
                    else if (dec.invalid)
                    begin
                        status_next = ST_INVALID;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + CW'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg && hit)
                begin
                    highest_next = e_start;
                    hsize_next   = e_size;
                    found_next   = 1'b1;
                end
                if ((rd_idx_reg == count_reg) && !pend_reg)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                p_next     = {1'b0, highest_reg} + {2'b00, hsize_reg};
                state_next = S_ALIGN;
            end
            S_ALIGN:
            begin
                if (!found_reg)
                begin
                    b_next = {2'b00, lo_reg};
                end
                else if (!dec_reg.z3 && dec_reg.mem && (dec_reg.phys == SZ_8M))
                begin
                    b_next = (p_reg == {1'b0, Z2_MEM_LOW}) ? {2'b00, Z2_MEM_LOW}
                                                           : {2'b00, Z2_MEM_HIGH};
                end
                else if (!dec_reg.z3 && dec_reg.mem && (dec_reg.phys == SZ_4M))
                begin
                    if (p_reg == {1'b0, Z2_MEM_LOW})
                        b_next = {2'b00, Z2_MEM_LOW};
                    else if (p_reg <= {1'b0, Z2_MEM_P2M})
                        b_next = {2'b00, Z2_MEM_P2M};
                    else if (p_reg <= {1'b0, Z2_MEM_P4M})
                        b_next = {2'b00, Z2_MEM_P4M};
                    else
                        b_next = {2'b00, Z2_MEM_HIGH};
                end
                else
                begin
                    b_next = aligned_w;
                end
                state_next = S_FIT;
            end
            S_FIT:
            begin
                if (end_w <= {2'b00, hi_reg})
                begin
                    status_next = ST_PLACED;
                    state_next  = S_FIN;
                end
                else if (!dec_reg.z3 && !dec_reg.mem && !xio_reg && cfg_xio)
                begin
                    xio_next     = 1'b1;
                    lo_next      = Z2_XIO_LOW;
                    hi_next      = Z2_XIO_HIGH;
                    highest_next = Z2_XIO_LOW;
                    hsize_next   = '0;
                    found_next   = 1'b0;
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    state_next   = S_SCAN;
                end
                else
                begin
                    status_next = dec_reg.cant_shutup ? ST_STOP : ST_SHUTUP;
                    state_next  = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.status = status_reg;
                    if ((status_reg != ST_INVALID) && (status_reg != ST_FULL))
                    begin
                        res_next.z3      = dec_reg.z3;
                        res_next.mem     = dec_reg.mem;
                        res_next.phys    = dec_reg.phys;
                        res_next.logical = dec_reg.logical;
                        res_next.needs   = dec_reg.needs;
                    end
                    if (status_reg == ST_PLACED)
                    begin
                        res_next.base = b_reg[31:0];
                        res_next.slot = new_slot;
                        ram_we        = 1'b1;
                        count_next    = count_reg + CW'(1);
                        slot_next     = new_slot;
                        related_next  = dec_reg.related;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            found_reg     <= 1'b0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            xio_reg       <= 1'b0;
            count_reg     <= '0;
            slot_reg      <= 5'd0;
            related_reg   <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            found_reg     <= found_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            xio_reg       <= xio_next;
            count_reg     <= count_next;
            slot_reg      <= slot_next;
            related_reg   <= related_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg     <= dec_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        highest_reg <= highest_next;
        hsize_reg   <= hsize_next;
        p_reg       <= p_next;
        b_reg       <= b_next;
        status_reg  <= status_next;
        res_reg     <= res_next;
    end

endmodule

@@ sv/expansion_board_autoconfig_placer.sv @@
// expansion_board_autoconfig_placer: top level of the board address placer.
// Depends on ebap_pkg, ebap_decode, ebap_seq, ebap_ram.
//
// Usage:
//   s_axis carries one request per probed board: tdata holds the raw type,
//   flags, manufacturer high and manufacturer low bytes. m_axis returns one
//   result per request with the status, assigned base, decoded bus/type,
//   physical and logical size, slot number and sizing flag.
//   cfg_wr_en/cfg_wr_data set third_gen_machine (enables the extra Zorro II
//   IO window); write it only while the block is idle.
//   A full table or an invalid board goes straight to the result state;
//   otherwise the sequencer scans the recorded boards, sums, aligns and
//   checks the fit before building the result. The table RAM is read one entry
//   per cycle through a single comparator, and an IO board that retries in
//   the extra window scans the table again.
//   One request is in flight at a time; s_axis_tready is high only when idle.
//   The result sits in an output register; a new request is taken while it
//   waits, and the sequencer holds its next result until m_axis_tready.
//   Reset empties the table, zeroes the slot counter and clears
//   third_gen_machine; the table RAM itself needs no clearing.
module expansion_board_autoconfig_placer
    import ebap_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // type_byte[7:0], flags_byte[15:8], maker_high[23:16], maker_low[31:24]
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // status[2:0], base_address[34:3], third_gen_board[35], memory_board[36],
    // physical_bytes[67:37], logical_bytes[98:68], slot_number[103:99],
    // needs_sizing[104], zero[111:105]
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             cfg_wr_en,
    input  logic             cfg_wr_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic               xio_reg;
    dec_t               dec;
    res_t               res;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xio_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            xio_reg <= cfg_wr_data;
        end
    end

    ebap_decode u_decode (
        .data (s_axis_tdata),
        .dec  (dec)
    );

    ebap_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .dec       (dec),
        .cfg_xio   (xio_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ebap_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tdata = {7'd0, res.needs, res.slot, res.logical, res.phys,
                           res.mem, res.z3, res.base, res.status};

endmodule

@@ sv/ebap_checker.sv @@
// ebap_checker: port-level assertions for the board placer, bound to the top.
// Depends on ebap_pkg and expansion_board_autoconfig_placer.
module ebap_checker
    import ebap_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    a_unplaced_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] != ST_PLACED)
        |-> (m_axis_tdata[34:3] == 32'd0) && (m_axis_tdata[103:99] == 5'd0))
        else $error("base or slot set on unplaced board");

    a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tdata[2:0] == ST_INVALID) || (m_axis_tdata[2:0] == ST_FULL))
        |-> (m_axis_tdata[OUT_W-1:3] == '0))
        else $error("fields set on rejected board");

    a_z3_window: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[2:0] == ST_PLACED) && m_axis_tdata[35]
        |-> (m_axis_tdata[34:3] >= Z3_LOW)
            && (({1'b0, m_axis_tdata[34:3]} + {2'b00, m_axis_tdata[67:37]})
                <= {1'b0, Z3_HIGH}))
        else $error("Zorro III board placed outside its window");

endmodule

bind expansion_board_autoconfig_placer ebap_checker u_ebap_checker (.*);

@@ tb/expansion_board_autoconfig_placer_test.sv @@
// Self-checking testbench for expansion_board_autoconfig_placer: directed and random board
// requests against a local placement predictor. Each result is checked field by field.
// Depends on ebap_pkg and the placer RTL.
`timescale 1ns / 100ps

module expansion_board_autoconfig_placer_test;
    import ebap_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 600_000;
    localparam int SETTLE      = 48;

    localparam logic [31:0] WIN_Z3_LO  = 32'h1000_0000;
    localparam logic [31:0] WIN_Z3_HI  = 32'h8000_0000;
    localparam logic [31:0] WIN_RAM_LO = 32'h0020_0000;
    localparam logic [31:0] WIN_RAM_HI = 32'h00a0_0000;
    localparam logic [31:0] WIN_IO_LO  = 32'h00e9_0000;
    localparam logic [31:0] WIN_IO_HI  = 32'h00f0_0000;
    localparam logic [31:0] WIN_XIO_LO = 32'h00a0_0000;
    localparam logic [31:0] WIN_XIO_HI = 32'h00b8_0000;
    localparam logic [63:0] BYTES_2M   = 64'h0020_0000;
    localparam logic [63:0] BYTES_4M   = 64'h0040_0000;
    localparam logic [63:0] BYTES_8M   = 64'h0080_0000;

    localparam logic [1:0] BUS_BAD0 = 2'd0;
    localparam logic [1:0] BUS_BAD1 = 2'd1;
    localparam logic [1:0] BUS_Z3   = 2'd2;
    localparam logic [1:0] BUS_Z2   = 2'd3;

    localparam logic [2:0] CODE_8M        = 3'd0;
    localparam logic [2:0] CODE_64K       = 3'd1;
    localparam logic [2:0] CODE_512K      = 3'd4;
    localparam logic [2:0] CODE_1M        = 3'd5;
    localparam logic [2:0] CODE_2M        = 3'd6;
    localparam logic [2:0] CODE_4M        = 3'd7;
    localparam logic [2:0] CODE_EXT_16M   = 3'd0;
    localparam logic [2:0] CODE_EXT_512M  = 3'd5;
    localparam logic [2:0] CODE_EXT_1G    = 3'd6;
    localparam logic [2:0] CODE_EXT_EMPTY = 3'd7;

    localparam logic [3:0] LOG_PHYS   = 4'd0;
    localparam logic [3:0] LOG_AUTO   = 4'd1;
    localparam logic [3:0] LOG_12M    = 4'd12;
    localparam logic [3:0] LOG_14M    = 4'd13;
    localparam logic [3:0] LOG_BAD_LO = 4'd14;
    localparam logic [3:0] LOG_BAD_HI = 4'd15;

    typedef struct packed {
        logic [7:0] maker_low;
        logic [7:0] maker_high;
        logic [7:0] flags_byte;
        logic [7:0] type_byte;
    } board_t;

    logic             clk;
    logic             rst_n          = 1'b0;
    logic             s_axis_tvalid  = 1'b0;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata   = '0;
    logic             m_axis_tvalid;
    logic             m_axis_tready  = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;
    logic             cfg_wr_en      = 1'b0;
    logic             cfg_wr_data    = 1'b0;

    // predictor copy of the board table
    logic [31:0] rec_start [DEPTH];
    logic [30:0] rec_size  [DEPTH];
    bit          rec_z3    [DEPTH];
    bit          rec_mem   [DEPTH];
    int          rec_count     = 0;
    logic [4:0]  slot_ctr      = '0;
    bit          prev_related  = 1'b1;
    bit          gen3_machine  = 1'b0;

    res_t        pending_results [$];
    res_t        want_result;
    int          status_tally [5];
    int          mismatches    = 0;
    int          results_seen  = 0;
    int          boards_sent   = 0;
    int          cycle_count   = 0;
    bit          idle_on       = 1'b1;
    bit          tx_holding    = 1'b0;
    int          rx_wait       = 0;
    int          rx_holdoff    = 0;

    expansion_board_autoconfig_placer #(
        .TABLE_DEPTH(DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [30:0] board_bytes(input bit extended, input logic [2:0] code);
        if (extended)
            return (code == CODE_EXT_EMPTY) ? 31'd0 : (31'h0100_0000 << code);
        if (code == CODE_8M)
            return 31'h0080_0000;
        return 31'h0001_0000 << (code - 1);
    endfunction

    function automatic logic [30:0] mapped_bytes(input logic [3:0] lcode, input bit mem,
                                                 input logic [30:0] phys);
        if (lcode == LOG_PHYS)
            return phys;
        if (lcode == LOG_AUTO)
            return mem ? 31'd0 : phys;
        if (lcode <= 4'd8)
            return 31'h0001_0000 << (lcode - 2);
        return 31'(31'h0020_0000 * (lcode - 6));
    endfunction

    // base just above the highest recorded board of the same kind in [lo, hi)
    function automatic bit find_base(input bit z3, input bit mem, input logic [30:0] size,
                                     input logic [31:0] lo, input logic [31:0] hi,
                                     output logic [31:0] base);
        logic [31:0] top;
        logic [63:0] top_end;
        logic [63:0] cand;
        logic [63:0] sz;
        bit          found;
        int          i;
        top   = lo;
        top_end = '0;
        found = 1'b0;
        sz    = {33'd0, size};
        for (i = 0; i < rec_count; i++)
        begin
            if (rec_z3[i] == z3 && rec_mem[i] == mem && rec_start[i] >= lo &&
                rec_start[i] < hi && rec_start[i] >= top)
            begin
                top     = rec_start[i];
                top_end = {32'd0, rec_start[i]} + {33'd0, rec_size[i]};
                found   = 1'b1;
            end
        end
        if (!found)
            cand = {32'd0, lo};
        else if (!z3 && mem && sz == BYTES_8M)
            cand = (top_end == {32'd0, lo}) ? {32'd0, lo} : {32'd0, hi};
        else if (!z3 && mem && sz == BYTES_4M)
        begin
            if (top_end == {32'd0, lo})
                cand = {32'd0, lo};
            else if (top_end <= {32'd0, lo} + BYTES_2M)
                cand = {32'd0, lo} + BYTES_2M;
            else if (top_end <= {32'd0, lo} + BYTES_4M)
                cand = {32'd0, lo} + BYTES_4M;
            else
                cand = {32'd0, hi};
        end
        else
            cand = (top_end + sz - 64'd1) & ~(sz - 64'd1);
        base = cand[31:0];
        return (cand + sz <= {32'd0, hi});
    endfunction

    function automatic res_t predict_board(input board_t b, input bit commit);
        res_t        r;
        logic [7:0]  fl;
        logic [15:0] maker;
        logic [3:0]  lcode;
        logic [30:0] phys;
        logic [31:0] base;
        logic [4:0]  next_slot;
        bit          z3;
        bit          mem;
        bit          fits;
        r     = '0;
        fl    = ~b.flags_byte;
        maker = ~{b.maker_high, b.maker_low};
        if (rec_count >= DEPTH)
        begin
            r.status = ST_FULL;
            return r;
        end
        if (b.type_byte[7:6] == BUS_BAD0 || b.type_byte[7:6] == BUS_BAD1)
        begin
            r.status = ST_INVALID;
            return r;
        end
        z3    = (b.type_byte[7:6] == BUS_Z3);
        mem   = b.type_byte[5];
        phys  = board_bytes(z3 && fl[5], b.type_byte[2:0]);
        lcode = z3 ? fl[3:0] : LOG_PHYS;
        if (phys == '0 || lcode > LOG_14M || maker == '0)
        begin
            r.status = ST_INVALID;
            return r;
        end
        r.z3      = z3;
        r.mem     = mem;
        r.phys    = phys;
        r.logical = mapped_bytes(lcode, mem, phys);
        r.needs   = mem && r.logical == '0;
        if (z3)
            fits = find_base(1'b1, mem, phys, WIN_Z3_LO, WIN_Z3_HI, base);
        else if (mem)
            fits = find_base(1'b0, 1'b1, phys, WIN_RAM_LO, WIN_RAM_HI, base);
        else
        begin
            fits = find_base(1'b0, 1'b0, phys, WIN_IO_LO, WIN_IO_HI, base);
            if (!fits && gen3_machine)
                fits = find_base(1'b0, 1'b0, phys, WIN_XIO_LO, WIN_XIO_HI, base);
        end
        if (!fits)
        begin
            r.status = fl[6] ? ST_STOP : ST_SHUTUP;
            return r;
        end
        next_slot = prev_related ? slot_ctr : slot_ctr + 5'd1;
        r.status  = ST_PLACED;
        r.base    = base;
        r.slot    = next_slot;
        if (commit)
        begin
            slot_ctr             = next_slot;
            rec_start[rec_count] = base;
            rec_size[rec_count]  = phys;
            rec_z3[rec_count]    = z3;
            rec_mem[rec_count]   = mem;
            rec_count++;
            prev_related         = b.type_byte[3];
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- result side

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                rx_wait = idle_on ? $urandom_range(0, 19) : 0;
            else if (rx_wait > 0)
                rx_wait--;
            if (rx_holdoff > 0)
                rx_holdoff--;
            m_axis_tready <= (rx_wait == 0 && rx_holdoff == 0);
        end
    end

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected: %h",
                             results_seen, m_axis_tdata);
            end
            else
            begin
                want_result = pending_results.pop_front();
                compare_field("status", 32'(want_result.status), 32'(m_axis_tdata[2:0]));
                compare_field("base_address", want_result.base, m_axis_tdata[34:3]);
                compare_field("third_gen_board", 32'(want_result.z3), 32'(m_axis_tdata[35]));
                compare_field("memory_board", 32'(want_result.mem), 32'(m_axis_tdata[36]));
                compare_field("physical_bytes", 32'(want_result.phys),
                              32'(m_axis_tdata[67:37]));
                compare_field("logical_bytes", 32'(want_result.logical),
                              32'(m_axis_tdata[98:68]));
                compare_field("slot_number", 32'(want_result.slot), 32'(m_axis_tdata[103:99]));
                compare_field("needs_sizing", 32'(want_result.needs), 32'(m_axis_tdata[104]));
            end
        end
    end

    // ---------------------------------------------------------------- request side

    function automatic logic [7:0] type_of(input logic [1:0] bus, input bit mem,
                                           input bit related, input logic [2:0] code);
        return {bus, mem, 1'b0, related, code};
    endfunction

    // raw flags byte, inverted on the bus
    function automatic logic [7:0] flags_of(input bit cant_shutup, input bit extended,
                                            input logic [3:0] lcode);
        return ~{1'b0, cant_shutup, extended, 1'b0, lcode};
    endfunction

    function automatic board_t mk_board(input logic [7:0] t, input logic [7:0] f);
        return {8'hbe, 8'h7d, f, t};
    endfunction

    function automatic board_t draw_board();
        board_t b;
        b.type_byte  = 8'($urandom);
        b.flags_byte = 8'($urandom);
        b.maker_high = 8'($urandom);
        b.maker_low  = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            b.type_byte[7] = 1'b1;
            if (b.type_byte[7:6] == BUS_Z3 && !b.flags_byte[5] &&
                b.type_byte[2:0] == CODE_EXT_EMPTY)
                b.type_byte[2:0] = 3'($urandom_range(0, 6));
            if (~b.flags_byte[3:0] > LOG_14M)
                b.flags_byte[3:0] = ~4'($urandom_range(0, 13));
            if ({b.maker_high, b.maker_low} == 16'hffff)
                b.maker_low[0] = 1'b0;
        end
        return b;
    endfunction

    // placements are rationed so the table fills late in the run
    function automatic board_t draw_gated();
        board_t b;
        res_t   peek;
        do
        begin
            b    = draw_board();
            peek = predict_board(b, 1'b0);
        end
        while (peek.status == ST_PLACED && $urandom_range(0, 59) != 0);
        return b;
    endfunction

    task automatic send_board(input board_t b);
        int   gap;
        res_t r;
        gap = idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0)
        begin
            if (tx_holding)
                s_axis_tvalid <= 1'b0;
            tx_holding = 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tx_holding = 1'b1;
        r = predict_board(b, 1'b1);
        pending_results.push_back(r);
        status_tally[r.status]++;
        boards_sent++;
    endtask

    task automatic park_sender();
        if (tx_holding)
            s_axis_tvalid <= 1'b0;
        tx_holding = 1'b0;
    endtask

    task automatic wait_drained();
        park_sender();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_machine_gen(input bit gen3);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= gen3;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        gen3_machine = gen3;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reject_invalid();
        write_machine_gen(1'b0);
        send_board(mk_board(type_of(BUS_BAD0, 1'b1, 1'b0, CODE_1M), flags_of(0, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_BAD1, 1'b0, 1'b1, CODE_64K), flags_of(1, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z3, 1'b1, 1'b0, CODE_EXT_EMPTY),
                            flags_of(0, 1, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z3, 1'b0, 1'b0, CODE_64K), flags_of(0, 0, LOG_BAD_LO)));
        send_board(mk_board(type_of(BUS_Z3, 1'b1, 1'b0, CODE_2M), flags_of(1, 0, LOG_BAD_HI)));
        send_board({8'hff, 8'hff, flags_of(0, 0, LOG_PHYS), type_of(BUS_Z2, 1'b0, 1'b0, CODE_64K)});
    endtask

    task automatic test_z2_memory_rules();
        // 64K then 2M, then a 4M board lands at base+4MB and fills the window
        send_board(mk_board(type_of(BUS_Z2, 1'b1, 1'b1, CODE_64K), flags_of(0, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z2, 1'b1, 1'b0, CODE_2M), flags_of(0, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z2, 1'b1, 1'b0, CODE_4M), flags_of(0, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z2, 1'b1, 1'b0, CODE_4M), flags_of(1, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z2, 1'b1, 1'b0, CODE_8M), flags_of(0, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z2, 1'b0, 1'b0, CODE_512K), flags_of(0, 0, LOG_PHYS)));
    endtask

    task automatic test_z3_and_io_placement();
        send_board(mk_board(type_of(BUS_Z3, 1'b1, 1'b0, CODE_EXT_1G), flags_of(0, 1, LOG_AUTO)));
        send_board(mk_board(type_of(BUS_Z3, 1'b1, 1'b0, CODE_EXT_512M),
                            flags_of(0, 1, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z3, 1'b1, 1'b0, CODE_EXT_16M), flags_of(1, 1, LOG_14M)));
        // IO board asking for sizing takes its physical size
        send_board(mk_board(type_of(BUS_Z3, 1'b0, 1'b0, CODE_64K), flags_of(0, 0, LOG_AUTO)));
        send_board({8'h00, 8'h00, 8'h00, 8'hd1});
    endtask

    task automatic test_extra_io_window();
        write_machine_gen(1'b1);
        send_board(mk_board(type_of(BUS_Z2, 1'b0, 1'b0, CODE_512K), flags_of(0, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z2, 1'b0, 1'b0, CODE_1M), flags_of(1, 0, LOG_PHYS)));
        send_board(mk_board(type_of(BUS_Z3, 1'b0, 1'b0, CODE_EXT_1G), flags_of(0, 1, LOG_12M)));
        send_board({8'hff, 8'hff, 8'hff, 8'hbf});
        send_board({8'h00, 8'h00, 8'hff, 8'hff});
        send_board({8'hff, 8'h00, 8'h00, 8'h3f});
    endtask

    task automatic test_random_mix(input int count, input bit gen3, input bit idle);
        int k;
        write_machine_gen(gen3);
        idle_on = idle;
        for (k = 0; k < count; k++)
        begin
            if ($urandom_range(0, 99) == 0)
                wait_drained();
            send_board(draw_gated());
        end
    endtask

    // receiver stalls long while requests keep coming, so the input stalls too
    task automatic test_output_backpressure();
        int k;
        wait_drained();
        idle_on    = 1'b0;
        rx_holdoff = 400;
        for (k = 0; k < 16; k++)
            send_board(draw_gated());
        wait_drained();
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reject_invalid();
        test_z2_memory_rules();
        test_z3_and_io_placement();
        test_extra_io_window();
        test_random_mix(200, 1'b1, 1'b1);
        test_random_mix(150, 1'b0, 1'b0);
        test_output_backpressure();
        test_random_mix(250, 1'b1, 1'b1);
        test_random_mix(230, 1'b0, 1'b1);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        $display("%0d board requests, %0d results: %0d placed, %0d invalid, %0d shut up,",
                 boards_sent, results_seen, status_tally[ST_PLACED], status_tally[ST_INVALID],
                 status_tally[ST_SHUTUP]);
        $display("%0d stop, %0d table full; %0d mismatches in %0d cycles",
                 status_tally[ST_STOP], status_tally[ST_FULL], mismatches, cycle_count);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
